>>> sv/lba_pkg.sv
package lba_pkg;
  localparam int BLOCKS = 64;
  localparam int FILES = 32;
  localparam int BW = $clog2(BLOCKS);
  localparam int FW = $clog2(FILES);
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int LW = 8;
  localparam logic [LW-1:0] LINK_FREE = 8'hFF;
  localparam logic [LW-1:0] LINK_END = 8'hFE;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_FREE  = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_MISSING  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] file_key;
    logic [6:0]  block_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] file_key_out;
    logic [5:0]  block_index;
    logic [6:0]  block_total;
    logic        last;
  } rsp_t;
endpackage

>>> sv/lba_if.sv
interface lba_req_if import lba_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [31:0] file_key;
  logic [6:0] block_count;
  modport source (output valid, mode, file_key, block_count, input ready);
  modport sink (input valid, mode, file_key, block_count, output ready);
endinterface

interface lba_rsp_if import lba_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [31:0] file_key_out;
  logic [5:0] block_index;
  logic [6:0] block_total;
  logic last;
  modport source (output valid, status, file_key_out, block_index, block_total, last,
                  input ready);
  modport sink (input valid, status, file_key_out, block_index, block_total, last,
                output ready);
endinterface

>>> sv/linked_block_allocator_unit.sv
// channel | dir | beat
// req     | in  | mode, file_key, block_count
// rsp     | out | status, file_key_out, block_index, block_total, last
// One request at a time; req.ready is high only in idle, after the last response beat is taken.
// Create: scan for the first block, then scan and link each further block, then record the file;
//   a failed create then frees the partial chain, reading and writing the link of each block.
// Delete: read and compare each table entry searched, free each block, shift each later entry.
// List: read the table entry of each file, then read the link of each block and emit it.
// Every beat passes through the wait state and holds there while rsp.ready is low.
// Reset clears the free map (one flop per block) and file count; no clearing pass.
module linked_block_allocator_unit import lba_pkg::*; (
  input logic clk,
  input logic rst,
  lba_req_if.sink req,
  lba_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LINK, S_ADD, S_FREE_RD, S_FREE_WR, S_DEL_RD, S_DEL_CMP,
    S_SH_RD, S_SH_WR, S_LS_RD, S_LS_TAB, S_LS_LINK, S_LS_EMIT, S_WAIT
  } state_t;

  state_t state, ret;
  req_t cur;
  logic [BLOCKS-1:0] busy;
  logic [FW:0] count;
  logic [BW-1:0] first, prev, blk;
  logic [CW-1:0] cnt, steps;
  logic [FW:0] idx;
  logic [CW-1:0] emitted;
  logic fail, fin;
  logic [BW-1:0] pend_a;
  logic [LW-1:0] pend_d;
  rsp_t out;
  logic ovalid;

  logic lk_we;
  logic [BW-1:0] lk_wa, lk_ra;
  logic [LW-1:0] lk_wd, lk_rd;
  logic tb_we;
  logic [FW-1:0] tb_wa, tb_ra;
  logic [32+BW+7-1:0] tb_wd, tb_rd;

  lba_ram #(.WIDTH(LW), .DEPTH(BLOCKS)) u_link (.clk, .we(lk_we), .waddr(lk_wa),
    .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  lba_ram #(.WIDTH(32+BW+7), .DEPTH(FILES)) u_tab (.clk, .we(tb_we), .waddr(tb_wa),
    .wdata(tb_wd), .raddr(tb_ra), .rdata(tb_rd));

  logic found;
  logic [BW-1:0] lowest;
  always_comb begin
    found = 1'b0;
    lowest = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        lowest = BW'(i);
      end
    end
  end

  logic [31:0] tb_key;
  logic [BW-1:0] tb_start;
  assign tb_key = tb_rd[32+BW+7-1 -: 32];
  assign tb_start = tb_rd[BW+7-1 -: BW];
  logic lk_is_blk;
  assign lk_is_blk = lk_rd < LW'(BLOCKS);

  logic [6:0] want;
  logic scan_done, more_chain, more_files;
  assign want = (cur.block_count == 7'd0) ? 7'd1 : cur.block_count;
  assign scan_done = (cnt + 7'd1) >= want;
  assign more_chain = lk_is_blk && (steps + 1'b1 < CW'(BLOCKS)) &&
                      (emitted + 1'b1 < CW'(BLOCKS));
  assign more_files = (idx + 1'b1 < count) && (emitted + 1'b1 < CW'(BLOCKS));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ovalid;
  assign rsp.status = out.status;
  assign rsp.file_key_out = out.file_key_out;
  assign rsp.block_index = out.block_index;
  assign rsp.block_total = out.block_total;
  assign rsp.last = out.last;

  function automatic rsp_t mk_beat(logic [2:0] st, logic [31:0] key, logic [BW-1:0] bi,
                                   logic [CW-1:0] bt, logic lst);
    rsp_t r;
    r.status = st;
    r.file_key_out = key;
    r.block_index = bi;
    r.block_total = bt;
    r.last = lst;
    return r;
  endfunction

  always_comb begin
    lk_we = 1'b0; lk_wa = blk; lk_wd = LINK_FREE; lk_ra = blk;
    tb_we = 1'b0; tb_wa = idx[FW-1:0]; tb_ra = idx[FW-1:0];
    tb_wd = {cur.file_key, first, cnt};
    unique case (state)
      S_SCAN: begin
        if (found) begin
          lk_we = 1'b1; lk_wa = lowest; lk_wd = LINK_END;
        end
      end
      S_LINK: begin
        lk_we = 1'b1; lk_wa = pend_a; lk_wd = pend_d;
      end
      S_ADD: begin
        tb_we = 1'b1; tb_wa = count[FW-1:0];
      end
      S_FREE_WR: lk_we = 1'b1;
      S_SH_RD: tb_ra = FW'(idx + 1'b1);
      S_SH_WR: begin
        tb_we = 1'b1; tb_wd = tb_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= '0; count <= '0; ovalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= '{req.mode, req.file_key, req.block_count};
          idx <= '0; cnt <= '0; emitted <= '0; fail <= 1'b0;
          unique case (mode_t'(req.mode))
            MODE_CREATE: begin
              if (count >= (FW+1)'(FILES)) begin
                out <= mk_beat(ST_FULL, req.file_key, '0, '0, 1'b1);
                ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
              end else begin
                state <= S_SCAN;
              end
            end
            MODE_DELETE: begin
              if (count == '0) begin
                out <= mk_beat(ST_MISSING, req.file_key, '0, '0, 1'b1);
                ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
              end else begin
                state <= S_DEL_RD;
              end
            end
            MODE_LIST: begin
              if (count == '0) begin
                out <= mk_beat(ST_EMPTY, 32'd0, '0, '0, 1'b1);
                ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
              end else begin
                state <= S_LS_RD;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (!found) begin
            if (cnt == '0) begin
              out <= mk_beat(ST_NO_FREE, cur.file_key, '0, '0, 1'b1);
              ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
            end else begin
              fail <= 1'b1; blk <= first; steps <= '0; state <= S_FREE_RD;
            end
          end else begin
            busy[lowest] <= 1'b1;
            prev <= lowest;
            cnt <= cnt + 1'b1;
            fin <= scan_done;
            if (cnt == '0) begin
              first <= lowest;
              if (scan_done) state <= S_ADD;
            end else begin
              pend_a <= prev; pend_d <= LW'(lowest); state <= S_LINK;
            end
          end
        end
        S_LINK: state <= fin ? S_ADD : S_SCAN;
        S_ADD: begin
          count <= count + 1'b1;
          out <= mk_beat(ST_OK, cur.file_key, first, cnt, 1'b1);
          ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
        end
        S_FREE_RD: state <= S_FREE_WR;
        S_FREE_WR: begin
          busy[blk] <= 1'b0;
          blk <= lk_rd[BW-1:0];
          steps <= steps + 1'b1;
          if (lk_is_blk && (steps + 1'b1 < CW'(BLOCKS))) begin
            state <= S_FREE_RD;
          end else if (fail) begin
            out <= mk_beat(ST_NO_SPACE, cur.file_key, '0, '0, 1'b1);
            ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_DEL_RD: state <= S_DEL_CMP;
        S_DEL_CMP: begin
          if (tb_key == cur.file_key) begin
            blk <= tb_start; steps <= '0; state <= S_FREE_RD;
          end else if (idx + 1'b1 >= count) begin
            out <= mk_beat(ST_MISSING, cur.file_key, '0, '0, 1'b1);
            ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
          end else begin
            idx <= idx + 1'b1; state <= S_DEL_RD;
          end
        end
        S_SH_RD: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            out <= mk_beat(ST_OK, cur.file_key, '0, '0, 1'b1);
            ovalid <= 1'b1; ret <= S_IDLE; state <= S_WAIT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx <= idx + 1'b1; state <= S_SH_RD;
        end
        S_LS_RD: state <= S_LS_TAB;
        S_LS_TAB: begin
          blk <= tb_start; cur.file_key <= tb_key; steps <= '0; state <= S_LS_LINK;
        end
        S_LS_LINK: state <= S_LS_EMIT;
        S_LS_EMIT: begin
          out <= mk_beat(ST_OK, cur.file_key, blk, '0, !more_chain && !more_files);
          ovalid <= 1'b1; state <= S_WAIT;
          emitted <= emitted + 1'b1;
          if (more_chain) begin
            blk <= lk_rd[BW-1:0]; steps <= steps + 1'b1; ret <= S_LS_LINK;
          end else if (more_files) begin
            idx <= idx + 1'b1; ret <= S_LS_RD;
          end else begin
            ret <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (rsp.ready) begin
            ovalid <= 1'b0; state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !rsp.ready |=> ovalid && $stable(out));
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ovalid);
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (FW+1)'(FILES));
  a_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) == ovalid);
endmodule

>>> sv/lba_ram.sv
module lba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
